// ===== hdl/mft_pkg.sv =====
// Package for the MAC filtering table: payload structs, command and status codes.
// Used by the top level module of the block; no dependencies.
`default_nettype none
package mft_pkg;
  localparam int TABLE_ENTRIES_D = 64;
  localparam int PORTS_D = 16;
  localparam int TIME_BITS_D = 32;

  localparam logic [2:0] CMD_LEARN  = 3'd0;
  localparam logic [2:0] CMD_UCAST  = 3'd1;
  localparam logic [2:0] CMD_MCAST  = 3'd2;
  localparam logic [2:0] CMD_STAGE  = 3'd3;
  localparam logic [2:0] CMD_COMMIT = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_MISS  = 3'd1;
  localparam logic [2:0] ST_AGED  = 3'd2;
  localparam logic [2:0] ST_MULTI = 3'd3;
  localparam logic [2:0] ST_NOTMC = 3'd4;
  localparam logic [2:0] ST_FULL  = 3'd5;

  localparam int GROUP_BIT = 40;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] mac_address;
    logic [31:0] time_stamp;
    logic [3:0]  port_number;
    logic [15:0] port_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  port_number_res;
    logic [15:0] port_mask_res;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hdl/mft_regs.sv =====
// APB-style configuration registers: aging enable and aging threshold.
// Depends on nothing but the clock and reset.
`default_nettype none
module mft_regs (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output logic             aging_enable,
  output logic [31:0]      aging_threshold
);
  localparam logic [2:0] ADDR_ENABLE = 3'd0;
  localparam logic [2:0] ADDR_THRESH = 3'd4;

  logic        en_r;
  logic [31:0] thr_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  // write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r  <= 1'b0;
      thr_r <= '0;
    end else if (wr) begin
      if (cfg_paddr == ADDR_ENABLE) en_r <= cfg_pwdata[0];
      if (cfg_paddr == ADDR_THRESH) thr_r <= cfg_pwdata;
    end
  end

  // read back
  always_comb begin
    case (cfg_paddr)
      ADDR_ENABLE: cfg_prdata = {31'd0, en_r};
      ADDR_THRESH: cfg_prdata = thr_r;
      default:     cfg_prdata = '0;
    endcase
  end

  assign aging_enable    = en_r;
  assign aging_threshold = thr_r;
endmodule
`default_nettype wire

// ===== hdl/mac_filtering_table_with_aging.sv =====
// Top level of the MAC filtering table with aging; holds the table memory and the
// sequencer. Depends on mft_pkg and mft_regs.
`default_nettype none
// Filtering database with two banks of TABLE_ENTRIES slots in one synchronous memory:
// the operational bank is learned into and looked up, the staging bank collects static
// entries and a commit swaps the two. A command is taken when start is high and busy is
// low. Learn, lookups and stage scan their bank one slot a cycle through the single read
// port: busy stays high through the read pipeline, the scan and the write-back, and the
// result is strobed on out_valid in the cycle after the write-back, in which the next
// command may already be taken; a command is not taken while the last is in progress.
// Commit clears the old operational bank one slot a cycle and then swaps the banks;
// unused commands go straight to the result. After reset both banks are cleared while
// busy is high. Each entry's valid bit sits in the memory word beside address, time
// and ports. The result is shown for one cycle and cannot be held off by the receiver.
module mac_filtering_table_with_aging #(
  parameter int TABLE_ENTRIES = mft_pkg::TABLE_ENTRIES_D,
  parameter int PORTS = mft_pkg::PORTS_D,
  parameter int TIME_BITS = mft_pkg::TIME_BITS_D
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire mft_pkg::in_item_t in_item,
  output logic                  out_valid,
  output mft_pkg::out_item_t    out_item,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [2:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import mft_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int SW = IW + 1;
  localparam int SLOTS = 2 ** SW;
  localparam int CW = IW + 1;
  localparam int TW = TIME_BITS;
  localparam int PW = PORTS;
  localparam int EW = 1 + 48 + TW + PW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_CLR  = 2'd3;

  logic          aging_enable;
  logic [31:0]   aging_threshold;

  mft_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .aging_enable, .aging_threshold
  );

  // table memory: {valid, address, time, ports}
  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd_data;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic             bank_r;
  logic [1:0]       state_r;
  in_item_t         cmd_r;
  logic [CW-1:0]    rcnt_r;   // read address counter, also the clearing counter
  logic [CW-1:0]    ccnt_r;   // index of data in rd_data
  logic             cval_r;   // rd_data holds a scanned entry
  logic             clr_bank_r;
  logic             init_r;   // clearing pass after reset
  logic             hit_r;
  logic [IW-1:0]    hit_idx_r;
  logic [TW-1:0]    hit_time_r;
  logic [PW-1:0]    hit_ports_r;
  logic             free_r;
  logic [IW-1:0]    free_idx_r;
  logic             ov_r;
  out_item_t        out_r;

  logic          scan_bank;
  logic          e_valid;
  logic [47:0]   e_addr;
  logic [TW-1:0] e_time;
  logic [PW-1:0] e_ports;
  logic [IW-1:0] cidx;
  logic [TW-1:0] now;

  assign scan_bank = (cmd_r.command == CMD_STAGE) ? ~bank_r : bank_r;
  assign rd_addr   = {scan_bank, rcnt_r[IW-1:0]};
  assign e_valid   = rd_data[EW-1];
  assign e_addr    = rd_data[EW-2 -: 48];
  assign e_time    = rd_data[PW +: TW];
  assign e_ports   = rd_data[PW-1:0];
  assign cidx      = ccnt_r[IW-1:0];
  assign now       = TW'(cmd_r.time_stamp);
  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = out_r;

  // result and write-back decision
  logic [PW-1:0] lport;
  logic [TW-1:0] age;
  logic          aged;
  logic          single;
  logic [3:0]    first_port;
  logic [SW-1:0] tgt;
  out_item_t     res;
  logic          do_wr;
  logic [EW-1:0] wdat;

  always_comb begin
    lport = '0;
    if (32'(cmd_r.port_number) < PORTS) lport[cmd_r.port_number] = 1'b1;
    age    = now - hit_time_r;
    aged   = aging_enable && (hit_time_r != '0) && (now >= hit_time_r) &&
             (64'(age) >= 64'(aging_threshold));
    single = (hit_ports_r != '0) && ((hit_ports_r & (hit_ports_r - 1'b1)) == '0);
    first_port = '0;
    for (int k = PW - 1; k >= 0; k--) begin
      if (hit_ports_r[k]) first_port = 4'(k);
    end
    res   = '0;
    do_wr = 1'b0;
    tgt   = {scan_bank, hit_r ? hit_idx_r : free_idx_r};
    wdat  = {1'b0, cmd_r.mac_address, hit_time_r, hit_ports_r};
    case (cmd_r.command)
      CMD_LEARN: begin
        if (hit_r || free_r) begin
          do_wr = 1'b1;
          wdat  = {1'b1, cmd_r.mac_address, now, lport};
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_UCAST, CMD_MCAST: begin
        if (cmd_r.command == CMD_MCAST && !cmd_r.mac_address[GROUP_BIT]) begin
          res.status = ST_NOTMC;
        end else if (!hit_r) begin
          res.status = ST_MISS;
        end else if (cmd_r.command == CMD_UCAST && !single) begin
          res.status = ST_MULTI;
        end else if (aged) begin
          res.status = ST_AGED;
          do_wr = 1'b1;
          wdat  = {1'b0, cmd_r.mac_address, hit_time_r, hit_ports_r};
        end else begin
          if (hit_time_r != '0) begin
            do_wr = 1'b1;
            wdat  = {1'b1, cmd_r.mac_address, now, hit_ports_r};
          end
          if (cmd_r.command == CMD_UCAST) res.port_number_res = first_port;
          else res.port_mask_res = 16'(hit_ports_r);
        end
      end
      CMD_STAGE: begin
        if (!hit_r) begin
          if (free_r) begin
            do_wr = 1'b1;
            wdat  = {1'b1, cmd_r.mac_address, {TW{1'b0}}, PW'(cmd_r.port_mask)};
          end else begin
            res.status = ST_FULL;
          end
        end
      end
      default: ;
    endcase
  end

  // write port: clearing pass or write-back
  assign wr_en   = (state_r == S_CLR) || ((state_r == S_DONE) && do_wr);
  assign wr_addr = (state_r == S_CLR) ? {clr_bank_r, rcnt_r[IW-1:0]} : tgt;
  assign wr_data = (state_r == S_CLR) ? '0 : wdat;

  // sequencer: scan the bank one entry a cycle, then write back; clear a bank for commit and after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      bank_r     <= 1'b0;
      ov_r       <= 1'b0;
      cval_r     <= 1'b0;
      rcnt_r     <= '0;
      clr_bank_r <= 1'b0;
      init_r     <= 1'b1;
    end else begin
      ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r      <= in_item;
            rcnt_r     <= '0;
            cval_r     <= 1'b0;
            hit_r      <= 1'b0;
            free_r     <= 1'b0;
            clr_bank_r <= bank_r;
            if (in_item.command inside {CMD_LEARN, CMD_UCAST, CMD_MCAST, CMD_STAGE})
              state_r <= S_SCAN;
            else if (in_item.command == CMD_COMMIT) state_r <= S_CLR;
            else state_r <= S_DONE;
          end
        end
        S_SCAN: begin
          if (rcnt_r < CW'(TABLE_ENTRIES)) rcnt_r <= rcnt_r + 1'b1;
          cval_r <= (rcnt_r < CW'(TABLE_ENTRIES));
          ccnt_r <= rcnt_r;
          if (cval_r) begin
            if (e_valid) begin
              if (!hit_r && e_addr == cmd_r.mac_address) begin
                hit_r       <= 1'b1;
                hit_idx_r   <= cidx;
                hit_time_r  <= e_time;
                hit_ports_r <= e_ports;
              end
            end else if (!free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= cidx;
            end
          end
          if (cval_r && ccnt_r == CW'(TABLE_ENTRIES - 1)) state_r <= S_DONE;
        end
        // clear one bank a slot per cycle; after reset clear both
        S_CLR: begin
          if (rcnt_r == CW'(TABLE_ENTRIES - 1)) begin
            rcnt_r <= '0;
            if (init_r && !clr_bank_r) begin
              clr_bank_r <= 1'b1;
            end else if (init_r) begin
              init_r  <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            rcnt_r <= rcnt_r + 1'b1;
          end
        end
        S_DONE: begin
          if (cmd_r.command == CMD_COMMIT) bank_r <= ~bank_r;
          out_r   <= res;
          ov_r    <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
